[rtl/rbsi_pkg.sv]
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared constants and types for the ray / box slab intersection pipeline.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int WORD_W              = 32;
   localparam int FRAC_BITS_DEF       = 16;
   // quotient bits resolved per divider stage
   localparam int DIV_STEPS_PER_STAGE = 4;
   localparam int CSR_IDX_W           = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_Z = 3'd5;

   localparam logic signed [WORD_W-1:0] BOX_MIN_RST = 32'sd0;
   localparam logic signed [WORD_W-1:0] BOX_MAX_RST = 32'sd65536;

   typedef logic signed [WORD_W-1:0] q_type;

   // slab distances, flags per axis
   typedef struct packed {
      q_type [2:0] t_lo;
      q_type [2:0] t_hi;
      logic  [2:0] zero;
      logic  [2:0] in_slab;
   } slab_type;

   // interval as it narrows down the axis stages
   typedef struct packed {
      q_type near;
      q_type far;
      logic  alive;
      logic  hit;
   } ivl_type;

   // sideband that rides alongside the dividers
   typedef struct packed {
      q_type       near;
      q_type       far;
      logic  [2:0] zero;
      logic  [2:0] in_slab;
      logic  [5:0] neg;
   } side_type;

endpackage

[rtl/rbsi_ifs.sv]
// ----------------------------------------------------------------------------
// rbsi_ifs
// Request and response channels: valid / ready with payload.
// ----------------------------------------------------------------------------
interface rbsi_req_if;
   logic          valid;
   logic          ready;
   logic [31:0]   origin_x;
   logic [31:0]   origin_y;
   logic [31:0]   origin_z;
   logic [31:0]   dir_x;
   logic [31:0]   dir_y;
   logic [31:0]   dir_z;
   logic [31:0]   near_in;
   logic [31:0]   far_in;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   near_in, far_in, input ready);
   modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   near_in, far_in, output ready);
endinterface

interface rbsi_rsp_if;
   logic          valid;
   logic          ready;
   logic          hit;
   logic [31:0]   near_out;
   logic [31:0]   far_out;

   modport source (output valid, hit, near_out, far_out, input ready);
   modport sink   (input valid, hit, near_out, far_out, output ready);
endinterface

[rtl/rbsi_div.sv]
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined unsigned restoring divider, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module rbsi_div #(
   parameter int NUM_W  = 49,
   parameter int STAGES = 13
) (
   input  logic              clock,
   input  logic [STAGES-1:0] en,
   input  logic [NUM_W-1:0]  num,
   input  logic [31:0]       den,
   output logic [NUM_W-1:0]  quo
);

   localparam int STEP_B = rbsi_pkg::DIV_STEPS_PER_STAGE;

   logic [31:0]      rem_ff [STAGES];
   logic [NUM_W-1:0] nq_ff  [STAGES];
   logic [31:0]      d_ff   [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_st
      logic [31:0]      rem_src;
      logic [NUM_W-1:0] nq_src;
      logic [31:0]      d_src;
      logic [31:0]      rem_in;
      logic [NUM_W-1:0] nq_in;

      // stage source: fresh operands or previous stage
      if (s == 0) begin : g_first
         assign rem_src = '0;
         assign nq_src  = num;
         assign d_src   = den;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign nq_src  = nq_ff[s-1];
         assign d_src   = d_ff[s-1];
      end

      // shift-subtract steps; numerator bits leave the top, quotient enters low
      always_comb begin
         logic [32:0] r2;
         logic        qb;
         rem_in = rem_src;
         nq_in  = nq_src;
         for (int k = 0; k < STEP_B; k++) begin
            if (s * STEP_B + k < NUM_W) begin
               r2 = {rem_in, nq_in[NUM_W-1]};
               qb = 1'b0;
               if (r2 >= {1'b0, d_src}) begin
                  r2 = r2 - {1'b0, d_src};
                  qb = 1'b1;
               end
               rem_in = r2[31:0];
               nq_in  = {nq_in[NUM_W-2:0], qb};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s] <= rem_in;
            nq_ff[s]  <= nq_in;
            d_ff[s]   <= d_src;
         end
      end
   end

   assign quo = nq_ff[STAGES-1];

endmodule

[rtl/rbsi_axis.sv]
// ----------------------------------------------------------------------------
// rbsi_axis
// One axis of the slab test: orders entry / exit and narrows the interval.
// ----------------------------------------------------------------------------
module rbsi_axis #(
   parameter int AXIS = 0,
   parameter bit LAST = 1'b0
) (
   input  logic               clock,
   input  logic               en,
   input  rbsi_pkg::slab_type slab_i,
   input  rbsi_pkg::ivl_type  ivl_i,
   output rbsi_pkg::slab_type slab_o,
   output rbsi_pkg::ivl_type  ivl_o
);

   rbsi_pkg::slab_type slab_ff;
   rbsi_pkg::ivl_type  ivl_ff;
   rbsi_pkg::ivl_type  ivl_in;
   rbsi_pkg::q_type    t1, t2, t_enter, t_leave, nn, ff;

   // entry / exit ordering and clamp of the interval
   always_comb begin
      t1      = slab_i.t_lo[AXIS];
      t2      = slab_i.t_hi[AXIS];
      t_enter = ($signed(t1) < $signed(t2)) ? t1 : t2;
      t_leave = ($signed(t1) < $signed(t2)) ? t2 : t1;
      nn      = ($signed(t_enter) > $signed(ivl_i.near)) ? t_enter : ivl_i.near;
      ff      = ($signed(t_leave) < $signed(ivl_i.far))  ? t_leave : ivl_i.far;
   end

   // update, reject, final decision on the last axis
   always_comb begin
      ivl_in = ivl_i;
      if (ivl_i.alive) begin
         if (!slab_i.zero[AXIS]) begin
            ivl_in.near = nn;
            ivl_in.far  = ff;
            if (!LAST && ($signed(nn) > $signed(ff))) begin
               ivl_in.alive = 1'b0;
            end
         end else if (!slab_i.in_slab[AXIS]) begin
            ivl_in.alive = 1'b0;
         end
      end
      if (LAST) begin
         ivl_in.hit = ivl_in.alive && ($signed(ivl_in.near) <= $signed(ivl_in.far));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         slab_ff <= slab_i;
         ivl_ff  <= ivl_in;
      end
   end

   assign slab_o = slab_ff;
   assign ivl_o  = ivl_ff;

endmodule

[rtl/ray_box_slab_intersect.sv]
// Pipeline: an input register, the divider stages, a saturate register and the X, Y, Z
//   axis registers lie between accepted word and response word.
// Throughput: one word per cycle; each stage holds under back-pressure and
//   empty stages close up, so a stalled response blocks the input only once
//   every stage holds a word.
// Reset: synchronous, clears all valid bits and loads the box to [0, 1.0]^3.
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Slab test of a ray interval against a configurable axis-aligned box.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect #(
   parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   rbsi_req_if.sink                       req_ch,
   rbsi_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [rbsi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);

   localparam int NUM_W  = 33 + FRAC_BITS;
   localparam int DIV_ST = (NUM_W + rbsi_pkg::DIV_STEPS_PER_STAGE - 1)
                           / rbsi_pkg::DIV_STEPS_PER_STAGE;
   localparam int ST_SAT = DIV_ST + 1;
   localparam int NST    = DIV_ST + 5;

   localparam logic [NUM_W-1:0] LIM_POS = NUM_W'(33'h0_7FFF_FFFF);
   localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'(33'h0_8000_0000);

   rbsi_pkg::q_type box_lo_ff [3];
   rbsi_pkg::q_type box_hi_ff [3];

   logic [NST-1:0] v_ff;
   logic [NST-1:0] en;

   rbsi_pkg::q_type org [3];
   rbsi_pkg::q_type dir [3];

   logic [32:0]        nmag_in [6];
   logic [31:0]        dmag_in [6];
   logic [32:0]        nmag_ff [6];
   logic [31:0]        dmag_ff [6];
   rbsi_pkg::side_type side_in;
   rbsi_pkg::side_type side_ff [DIV_ST+1];
   logic [NUM_W-1:0]   quo [6];

   rbsi_pkg::slab_type slab_in, slab_ff;
   rbsi_pkg::ivl_type  ivl0_in, ivl0_ff;
   rbsi_pkg::slab_type slab_x, slab_y, slab_z;
   rbsi_pkg::ivl_type  ivl_x, ivl_y, ivl_z;

   // box registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            box_lo_ff[a] <= rbsi_pkg::BOX_MIN_RST;
            box_hi_ff[a] <= rbsi_pkg::BOX_MAX_RST;
         end
      end else if (csr_we) begin
         case (csr_index)
            rbsi_pkg::CSR_MIN_X: box_lo_ff[0] <= csr_wdata;
            rbsi_pkg::CSR_MIN_Y: box_lo_ff[1] <= csr_wdata;
            rbsi_pkg::CSR_MIN_Z: box_lo_ff[2] <= csr_wdata;
            rbsi_pkg::CSR_MAX_X: box_hi_ff[0] <= csr_wdata;
            rbsi_pkg::CSR_MAX_Y: box_hi_ff[1] <= csr_wdata;
            rbsi_pkg::CSR_MAX_Z: box_hi_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage enables: a stage moves when empty or when the next one moves
   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp_ch.ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ch.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_ch.valid;
         for (int k = 1; k < NST; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // front stage: differences, magnitudes, signs, parallel tests
   assign org[0] = req_ch.origin_x;
   assign org[1] = req_ch.origin_y;
   assign org[2] = req_ch.origin_z;
   assign dir[0] = req_ch.dir_x;
   assign dir[1] = req_ch.dir_y;
   assign dir[2] = req_ch.dir_z;

   always_comb begin
      logic [32:0]     diff;
      rbsi_pkg::q_type bnd;
      side_in.near = req_ch.near_in;
      side_in.far  = req_ch.far_in;
      for (int a = 0; a < 3; a++) begin
         side_in.zero[a]    = (dir[a] == '0);
         side_in.in_slab[a] = ($signed(org[a]) >= $signed(box_lo_ff[a])) &&
                              ($signed(org[a]) <= $signed(box_hi_ff[a]));
      end
      for (int j = 0; j < 6; j++) begin
         bnd         = (j < 3) ? box_lo_ff[j % 3] : box_hi_ff[j % 3];
         diff        = {bnd[31], bnd} - {org[j % 3][31], org[j % 3]};
         nmag_in[j]  = diff[32] ? (~diff + 33'd1) : diff;
         dmag_in[j]  = dir[j % 3][31] ? (~dir[j % 3] + 32'd1) : dir[j % 3];
         side_in.neg[j] = diff[32] ^ dir[j % 3][31];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         nmag_ff    <= nmag_in;
         dmag_ff    <= dmag_in;
         side_ff[0] <= side_in;
      end
      for (int s = 1; s <= DIV_ST; s++) begin
         if (en[s]) side_ff[s] <= side_ff[s-1];
      end
   end

   // six dividers: lower bounds then upper bounds
   for (genvar j = 0; j < 6; j++) begin : g_div
      rbsi_div #(
         .NUM_W  (NUM_W),
         .STAGES (DIV_ST)
      ) u_div (
         .clock (clock),
         .en    (en[DIV_ST:1]),
         .num   ({nmag_ff[j], {FRAC_BITS{1'b0}}}),
         .den   (dmag_ff[j]),
         .quo   (quo[j])
      );
   end

   // sign and saturate to 32 bits
   always_comb begin
      rbsi_pkg::q_type t;
      for (int j = 0; j < 6; j++) begin
         if (side_ff[DIV_ST].neg[j]) begin
            t = (quo[j] > LIM_NEG) ? 32'sh8000_0000 : (~quo[j][31:0] + 32'd1);
         end else begin
            t = (quo[j] > LIM_POS) ? 32'sh7FFF_FFFF : quo[j][31:0];
         end
         if (j < 3) slab_in.t_lo[j % 3] = t;
         else       slab_in.t_hi[j % 3] = t;
      end
      slab_in.zero    = side_ff[DIV_ST].zero;
      slab_in.in_slab = side_ff[DIV_ST].in_slab;
      ivl0_in.near    = side_ff[DIV_ST].near;
      ivl0_in.far     = side_ff[DIV_ST].far;
      ivl0_in.alive   = 1'b1;
      ivl0_in.hit     = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en[ST_SAT]) begin
         slab_ff <= slab_in;
         ivl0_ff <= ivl0_in;
      end
   end

   // axis stages in order X, Y, Z
   rbsi_axis #(.AXIS(0), .LAST(1'b0)) u_ax_x (
      .clock (clock), .en (en[ST_SAT+1]),
      .slab_i (slab_ff), .ivl_i (ivl0_ff), .slab_o (slab_x), .ivl_o (ivl_x)
   );
   rbsi_axis #(.AXIS(1), .LAST(1'b0)) u_ax_y (
      .clock (clock), .en (en[ST_SAT+2]),
      .slab_i (slab_x), .ivl_i (ivl_x), .slab_o (slab_y), .ivl_o (ivl_y)
   );
   rbsi_axis #(.AXIS(2), .LAST(1'b1)) u_ax_z (
      .clock (clock), .en (en[ST_SAT+3]),
      .slab_i (slab_y), .ivl_i (ivl_y), .slab_o (slab_z), .ivl_o (ivl_z)
   );

   assign rsp_ch.valid    = v_ff[NST-1];
   assign rsp_ch.hit      = ivl_z.hit;
   assign rsp_ch.near_out = ivl_z.near;
   assign rsp_ch.far_out  = ivl_z.far;

`ifndef SYNTH
   // a hit always reports a non-empty interval
   a_hit_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.hit |-> $signed(rsp_ch.near_out) <= $signed(rsp_ch.far_out))
      else $error("hit with near beyond far");

   // input only backs up when the whole pipe is full and the output stalls
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (v_ff == '1) && !rsp_ch.ready)
      else $error("input stalled with room in the pipe");

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response word after reset");

   // a held response word does not change
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> $stable(ivl_z))
      else $error("stalled response changed");
`endif

endmodule
